// ----- hdl/slsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slsd_pkg;

	// Time counter width default
	localparam int TIME_BITS_DEF = 32;

	// Input opcodes
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_TICK   = 2'd1,
		OP_SENT   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 8;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOUD_THRESHOLD = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAMES_NEEDED  = 8'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN_MS     = 8'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN_MS    = 8'd3;
	localparam int CFG_DATA_BITS = 16;

	// Reset values of the registers
	localparam logic [14:0] LOUD_THRESHOLD_RST = 15'd2300;
	localparam logic [7:0]  FRAMES_NEEDED_RST  = 8'd4;
	localparam logic [15:0] SUSTAIN_MS_RST     = 16'd150;
	localparam logic [15:0] COOLDOWN_MS_RST    = 16'd2000;

	// Saturation limits
	localparam logic [14:0] PEAK_MAX  = 15'h7fff;
	localparam logic [7:0]  COUNT_MAX = 8'hff;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] sample;
		logic               frame_last;
		logic               armed;
	} item_t;

	typedef struct packed {
		logic        alert;
		logic [14:0] frame_peak;
		logic        frame_loud;
		logic [7:0]  run_length;
	} result_t;

	typedef struct packed {
		logic [14:0] loud_threshold;
		logic [7:0]  frames_needed;
		logic [15:0] sustain_ms;
		logic [15:0] cooldown_ms;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/slsd_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slsd_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [slsd_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  wire logic [slsd_pkg::CFG_DATA_BITS-1:0] wr_data,
	output slsd_pkg::cfg_t                         cfg
);
	import slsd_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loud_threshold <= LOUD_THRESHOLD_RST;
			cfg_q.frames_needed  <= FRAMES_NEEDED_RST;
			cfg_q.sustain_ms     <= SUSTAIN_MS_RST;
			cfg_q.cooldown_ms    <= COOLDOWN_MS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_LOUD_THRESHOLD: cfg_q.loud_threshold <= wr_data[14:0];
				REG_FRAMES_NEEDED:  cfg_q.frames_needed  <= wr_data[7:0];
				REG_SUSTAIN_MS:     cfg_q.sustain_ms     <= wr_data;
				REG_COOLDOWN_MS:    cfg_q.cooldown_ms    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/slsd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slsd_core #(
	parameter int TIME_BITS = slsd_pkg::TIME_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  slsd_pkg::item_t      item,
	input  slsd_pkg::cfg_t       cfg,
	output logic                 res_valid,
	output slsd_pkg::result_t    res
);
	import slsd_pkg::*;

	logic [TIME_BITS-1:0] now_ms_q;
	logic [TIME_BITS-1:0] run_start_ms_q;
	logic [TIME_BITS-1:0] last_alert_ms_q;
	logic [14:0]          running_peak_q;
	logic                 run_active_q;
	logic [7:0]           loud_run_count_q;

	logic [15:0]          neg_sample;
	logic [14:0]          mag;
	logic [14:0]          peak;
	logic                 is_sample;
	logic                 frame_end;
	logic                 loud;
	logic [7:0]           count_next;
	logic [TIME_BITS-1:0] start_next;
	logic [TIME_BITS-1:0] held;
	logic [TIME_BITS-1:0] since;
	logic                 alert;

	// Absolute value, most negative sample saturates
	always_comb begin
		neg_sample = 16'(-item.sample);
		if (!item.sample[15]) begin
			mag = item.sample[14:0];
		end else if (item.sample == 16'sh8000) begin
			mag = PEAK_MAX;
		end else begin
			mag = neg_sample[14:0];
		end
	end

	// Frame peak including this sample
	assign peak      = (mag > running_peak_q) ? mag : running_peak_q;
	assign is_sample = fire && (op_t'(item.op) == OP_SAMPLE);
	assign frame_end = is_sample && item.frame_last;
	assign res_valid = frame_end && item.armed;

	// Run update and alert decision
	always_comb begin
		loud = peak > cfg.loud_threshold;
		if (!run_active_q) begin
			count_next = 8'd1;
			start_next = now_ms_q;
		end else begin
			count_next = (loud_run_count_q == COUNT_MAX) ? COUNT_MAX
				: loud_run_count_q + 8'd1;
			start_next = run_start_ms_q;
		end
		held  = now_ms_q - start_next;
		since = now_ms_q - last_alert_ms_q;
		alert = loud && (count_next >= cfg.frames_needed)
			&& (held >= TIME_BITS'(cfg.sustain_ms))
			&& (since > TIME_BITS'(cfg.cooldown_ms));
	end

	// Advance state on each processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_ms_q         <= '0;
			run_start_ms_q   <= '0;
			last_alert_ms_q  <= '0;
			running_peak_q   <= '0;
			run_active_q     <= 1'b0;
			loud_run_count_q <= '0;
		end else if (fire) begin
			case (op_t'(item.op))
				OP_TICK: now_ms_q <= now_ms_q + TIME_BITS'(1);
				OP_SENT: last_alert_ms_q <= now_ms_q;
				OP_SAMPLE: begin
					running_peak_q <= item.frame_last ? 15'd0 : peak;
					if (item.frame_last && item.armed) begin
						if (!loud || alert) begin
							run_active_q     <= 1'b0;
							loud_run_count_q <= '0;
						end else begin
							run_active_q     <= 1'b1;
							loud_run_count_q <= count_next;
						end
						if (loud && !run_active_q) begin
							run_start_ms_q <= now_ms_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Result word
	always_comb begin
		res.alert      = alert;
		res.frame_peak = peak;
		res.frame_loud = loud;
		res.run_length = (!loud || alert) ? 8'd0 : count_next;
	end

endmodule

`default_nettype wire

// ----- hdl/sustained_loud_sound_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one input word per cycle; the only stall comes from a stalled result.
// Each word passes an input register, then one compare/update step into the result register.
// Reset (arst_n low, asynchronous): registers return to defaults, time and run state clear.
module sustained_loud_sound_detector #(
	parameter int TIME_BITS = slsd_pkg::TIME_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  slsd_pkg::item_t                        item,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output slsd_pkg::result_t                      result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [slsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [slsd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import slsd_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_free;
	logic    fire;
	logic    res_valid;
	result_t res;
	result_t result_q;
	logic    result_valid_q;

	assign cfg_ready = 1'b1;

	slsd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake between the stages
	assign out_free   = !result_valid_q || !result_stall;
	assign fire       = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	slsd_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
